### rtl/core/cdq_pkg.sv
// Package for the circular deque: command and state codes, field widths,
// reset constants. No dependencies.
`default_nettype none

package cdq_pkg;

    // field widths fixed by the item format
    localparam int CAP_W   = 7;
    localparam int VAL_W   = 32;
    localparam int CMD_W   = 3;

    // build-time defaults
    localparam int DEPTH_DEF = 64;
    localparam int CAP_RESET = 64;

    localparam logic [VAL_W-1:0] EMPTY_WORD = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_QUERY      = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_PUSH_REAR  = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_POP_REAR   = 3'd4
    } t_cmd;

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } t_state;

endpackage

`default_nettype wire

### rtl/core/cdq_chan_if.sv
// Valid/ready channel interfaces for the circular deque command and result
// streams. Depends on cdq_pkg.
`default_nettype none

interface cdq_cmd_if
    import cdq_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [VAL_W-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface cdq_rsp_if
    import cdq_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             ok;
    logic [VAL_W-1:0] front_value;
    logic [VAL_W-1:0] rear_value;
    logic             is_empty;
    logic             is_full;
    logic [CAP_W-1:0] entry_total;

    modport source (output valid, output ok, output front_value, output rear_value,
                    output is_empty, output is_full, output entry_total, input ready);
    modport sink   (input valid, input ok, input front_value, input rear_value,
                    input is_empty, input is_full, input entry_total, output ready);
endinterface

`default_nettype wire

### rtl/core/cdq_ram.sv
// Slot store of the deque: one write port, two registered read ports, with
// write-to-read forwarding on the same edge. Depends on cdq_pkg.
`default_nettype none

module cdq_ram
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [VAL_W-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr_front,
    input  wire logic [AW-1:0]    i_raddr_rear,
    output logic      [VAL_W-1:0] o_rdata_front,
    output logic      [VAL_W-1:0] o_rdata_rear
);

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rd_front;
    logic [VAL_W-1:0] r_rd_rear;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read ports; a write to the same slot on this edge is forwarded
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr_front)) begin
                r_rd_front <= i_wdata;
            end else begin
                r_rd_front <= r_mem[i_raddr_front];
            end
            if (i_we && (i_waddr == i_raddr_rear)) begin
                r_rd_rear <= i_wdata;
            end else begin
                r_rd_rear <= r_mem[i_raddr_rear];
            end
        end
    end

    assign o_rdata_front = r_rd_front;
    assign o_rdata_rear  = r_rd_rear;

endmodule

`default_nettype wire

### rtl/core/cdq_ctrl.sv
// Deque control: head pointer, entry count, capacity register, command
// decode, slot write and end-slot lookups, result register.
// Depends on cdq_pkg and the channel interfaces.
`default_nettype none

module cdq_ctrl
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = 6,
    parameter int CW    = 7
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CAP_W-1:0] i_cfg_data,
    cdq_cmd_if.sink               i_in,
    cdq_rsp_if.source             o_out,
    output logic                  o_we,
    output logic      [AW-1:0]    o_waddr,
    output logic      [VAL_W-1:0] o_wdata,
    output logic                  o_re,
    output logic      [AW-1:0]    o_raddr_front,
    output logic      [AW-1:0]    o_raddr_rear,
    input  wire logic [VAL_W-1:0] i_rdata_front,
    input  wire logic [VAL_W-1:0] i_rdata_rear
);

    // arithmetic width: holds front + count + capacity without overflow
    localparam int XW = ((CW > CAP_W) ? CW : CAP_W) + 1;
    localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);
    localparam int CAP_RST_I = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;
    localparam logic [CAP_W-1:0] CAP_RST = CAP_W'(CAP_RST_I);

    t_state r_state, n_state;

    logic [AW-1:0]    r_front, n_front;
    logic [CW-1:0]    r_count, n_count;
    logic [CAP_W-1:0] r_cap,   n_cap;
    logic             r_ok,    n_ok;

    logic             r_out_valid;
    logic             r_out_ok;
    logic [VAL_W-1:0] r_out_front;
    logic [VAL_W-1:0] r_out_rear;
    logic             r_out_empty;
    logic             r_out_full;
    logic [CAP_W-1:0] r_out_total;

    logic             in_xfer;
    logic             out_free;
    logic             load_out;

    logic [XW-1:0] fx, nx, cx, sum_fn, sum_fn_m1, tail_slot, rear_slot;
    logic [XW-1:0] nfx, nnx, sum_new, rear_new;
    logic [XW-1:0] cfg_x, cfg_clamp;
    logic          is_full, is_empty;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign load_out = (r_state == ST_LOOKUP) && out_free;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (in_xfer)  n_state = ST_LOOKUP;
            ST_LOOKUP: if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        i_in.ready = 1'b0;
        unique case (r_state)
            ST_IDLE:   i_in.ready = 1'b1;
            ST_LOOKUP: i_in.ready = 1'b0;
            default:   i_in.ready = 1'b0;
        endcase
    end

    // ring arithmetic on the current pointers
    always_comb begin
        fx        = XW'(r_front);
        nx        = XW'(r_count);
        cx        = XW'(r_cap);
        is_full   = (nx >= cx);
        is_empty  = (r_count == '0);
        sum_fn    = fx + nx;
        tail_slot = (sum_fn >= cx) ? (sum_fn - cx) : sum_fn;
        sum_fn_m1 = sum_fn - XW'(1);
        rear_slot = (sum_fn_m1 >= cx) ? (sum_fn_m1 - cx) : sum_fn_m1;
    end

    // command decode, slot write
    always_comb begin
        n_front = r_front;
        n_count = r_count;
        n_ok    = 1'b0;
        o_we    = 1'b0;
        o_waddr = r_front;
        o_wdata = EMPTY_WORD;
        unique case (t_cmd'(i_in.cmd))
            CMD_QUERY: begin
                n_ok = 1'b1;
            end
            CMD_PUSH_FRONT: begin
                if (!is_full) begin
                    if (is_empty) begin
                        n_front = '0;
                    end else if (r_front == '0) begin
                        n_front = AW'(cx - XW'(1));
                    end else begin
                        n_front = r_front - AW'(1);
                    end
                    o_we    = 1'b1;
                    o_waddr = n_front;
                    o_wdata = i_in.value;
                    n_count = r_count + CW'(1);
                    n_ok    = 1'b1;
                end
            end
            CMD_PUSH_REAR: begin
                if (!is_full) begin
                    o_we    = 1'b1;
                    o_waddr = AW'(tail_slot);
                    o_wdata = i_in.value;
                    n_count = r_count + CW'(1);
                    n_ok    = 1'b1;
                end
            end
            CMD_POP_FRONT: begin
                if (!is_empty) begin
                    o_we    = 1'b1;
                    o_waddr = r_front;
                    n_front = ((fx + XW'(1)) == cx) ? '0 : (r_front + AW'(1));
                    n_count = r_count - CW'(1);
                    n_ok    = 1'b1;
                end
            end
            CMD_POP_REAR: begin
                if (!is_empty) begin
                    o_we    = 1'b1;
                    o_waddr = AW'(rear_slot);
                    n_count = r_count - CW'(1);
                    n_ok    = 1'b1;
                end
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
        if (!in_xfer) begin
            o_we = 1'b0;
        end
    end

    // end slots after the command
    always_comb begin
        nfx      = XW'(n_front);
        nnx      = XW'(n_count);
        sum_new  = nfx + nnx - XW'(1);
        rear_new = (sum_new >= cx) ? (sum_new - cx) : sum_new;
    end

    assign o_re          = in_xfer;
    assign o_raddr_front = n_front;
    assign o_raddr_rear  = AW'(rear_new);

    // capacity write, clamped to 1..DEPTH; taken only while the deque is empty
    always_comb begin
        cfg_x     = XW'(i_cfg_data);
        cfg_clamp = (cfg_x == '0) ? XW'(1) : ((cfg_x > DEPTH_X) ? DEPTH_X : cfg_x);
        n_cap     = r_cap;
        if (i_cfg_we && is_empty) begin
            n_cap = CAP_W'(cfg_clamp);
        end
    end

    // deque state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_front <= '0;
            r_count <= '0;
            r_cap   <= CAP_RST;
            r_ok    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cap   <= n_cap;
            if (in_xfer) begin
                r_front <= n_front;
                r_count <= n_count;
                r_ok    <= n_ok;
            end else if (i_cfg_we && is_empty) begin
                r_front <= '0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_ok    <= r_ok;
            r_out_front <= is_empty ? EMPTY_WORD : i_rdata_front;
            r_out_rear  <= is_empty ? EMPTY_WORD : i_rdata_rear;
            r_out_empty <= is_empty;
            r_out_full  <= is_full;
            r_out_total <= CAP_W'(r_count);
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.ok          = r_out_ok;
    assign o_out.front_value = r_out_front;
    assign o_out.rear_value  = r_out_rear;
    assign o_out.is_empty    = r_out_empty;
    assign o_out.is_full     = r_out_full;
    assign o_out.entry_total = r_out_total;

endmodule

`default_nettype wire

### rtl/core/circular_deque.sv
// Top level of the circular deque: control and slot store.
// Depends on cdq_pkg, the channel interfaces, cdq_ctrl and cdq_ram.
//
//  channel   dir  fields                                              transfer
//  i_in      in   cmd, value                                          valid & ready
//  o_out     out  ok, front_value, rear_value, is_empty, is_full,     valid & ready
//                 entry_total
//  i_cfg_*   in   capacity (i_cfg_data)                               i_cfg_we
//
// For each command, the transfer edge updates the pointers, writes the slot
// of a successful push or pop and launches both end-slot reads; the result
// register loads from the registered read ports once o_out is free.
// A result waiting on o_out does not block the next command transfer.
// Synchronous reset clears pointers and count; capacity resets to 64
// (at most DEPTH). The slot store needs no clearing pass.
`default_nettype none

module circular_deque
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CAP_W-1:0] i_cfg_data,
    cdq_cmd_if.sink               i_in,
    cdq_rsp_if.source             o_out
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic             we;
    logic [AW-1:0]    waddr;
    logic [VAL_W-1:0] wdata;
    logic             re;
    logic [AW-1:0]    raddr_front;
    logic [AW-1:0]    raddr_rear;
    logic [VAL_W-1:0] rdata_front;
    logic [VAL_W-1:0] rdata_rear;

    cdq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in          (i_in),
        .o_out         (o_out),
        .o_we          (we),
        .o_waddr       (waddr),
        .o_wdata       (wdata),
        .o_re          (re),
        .o_raddr_front (raddr_front),
        .o_raddr_rear  (raddr_rear),
        .i_rdata_front (rdata_front),
        .i_rdata_rear  (rdata_rear)
    );

    cdq_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk         (i_clk),
        .i_we          (we),
        .i_waddr       (waddr),
        .i_wdata       (wdata),
        .i_re          (re),
        .i_raddr_front (raddr_front),
        .i_raddr_rear  (raddr_rear),
        .o_rdata_front (rdata_front),
        .o_rdata_rear  (rdata_rear)
    );

endmodule

`default_nettype wire
